// File: sv/cpd_pkg.sv
// Package for the caption packet deframer: payload structs, constants, ctl/dp link.
// No dependencies.
`timescale 1ns / 1ps
package cpd_pkg;

  localparam int unsigned MaxPairsDefault = 63;

  localparam logic [7:0] SYNC0   = 8'h96;
  localparam logic [7:0] SYNC1   = 8'h69;
  localparam logic [7:0] ID_TC   = 8'h71;
  localparam logic [7:0] ID_CC   = 8'h72;
  localparam logic [7:0] ID_SVC  = 8'h73;
  localparam logic [7:0] ID_FOOT = 8'h74;
  localparam logic [7:0] ID_PAD  = 8'hFF;
  localparam logic [7:0] ID_FUT0 = 8'h75;
  localparam logic [7:0] ID_FUT1 = 8'hEF;

  localparam logic [2:0] SEC_ID      = 3'd0;
  localparam logic [2:0] SEC_SKIP    = 3'd1;
  localparam logic [2:0] SEC_CCCOUNT = 3'd2;
  localparam logic [2:0] SEC_TRIPLET = 3'd3;
  localparam logic [2:0] SEC_SVCCNT  = 3'd4;
  localparam logic [2:0] SEC_FUTLEN  = 3'd5;
  localparam logic [2:0] SEC_DEAD    = 3'd6;

  localparam logic KIND_PAIR = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       resync;
  } in_item_t;

  typedef struct packed {
    logic       record_kind;
    logic [1:0] channel;
    logic [1:0] pair_type;
    logic [7:0] pair_first;
    logic [7:0] pair_second;
    logic [3:0] rate_code;
    logic [7:0] packet_size;
    logic       sum_good;
    logic       pairs_lost;
    logic [7:0] shortest_seen;
    logic [7:0] longest_seen;
    logic       last;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic take_byte;   // parse the accepted byte
    logic rd_start;    // start pair store read at index 0
    logic rd_next;     // advance read index
    logic load_pair;   // load output register from store read data
    logic load_end;    // load output register with end record
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic finish;      // byte just taken ended a packet
    logic good;        // packet of that end is good
    logic more_pairs;  // read index still below pair count
  } sts_t;

endpackage

// File: sv/cpd_datapath.sv
// Datapath: hunt, section parser, pair store, statistics and output register.
// Depends on cpd_pkg.
`timescale 1ns / 1ps
module cpd_datapath #(
  parameter int unsigned MaxPairs = cpd_pkg::MaxPairsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cpd_pkg::in_item_t   in_i,
  input  cpd_pkg::cmd_t       cmd_i,
  output cpd_pkg::sts_t       sts_o,
  output cpd_pkg::out_item_t  out_o
);
  localparam int unsigned IdxW = $clog2(MaxPairs);
  localparam int unsigned CntW = $clog2(MaxPairs + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MaxPairs);

  logic [1:0]  hunt_q, hunt_d;
  logic [7:0]  bidx_q, bidx_d, len_q, len_d, sum_q, sum_d, rem_q, rem_d;
  logic [2:0]  sec_q, sec_d, tflags_q, tflags_d;
  logic [1:0]  tph_q, tph_d;
  logic [7:0]  first_q, first_d;
  logic [CntW-1:0] cnt_q, cnt_d, rd_q, rd_addr;
  logic        ovf_q, ovf_d;
  logic [3:0]  rate_q, rate_d;
  logic [7:0]  min_q, min_d, max_q, max_d;
  logic        fin_q, fin_d, good_q, good_d;
  logic        wr_en;
  logic [17:0] wr_data, rd_data;
  logic [17:0] store [MaxPairs];

  logic [7:0] b;
  assign b = in_i.data_byte;

  always_comb begin
    logic [1:0] h;
    logic [7:0] nb;
    logic       fin;
    h = hunt_q; hunt_d = hunt_q; bidx_d = bidx_q; len_d = len_q; sum_d = sum_q;
    rem_d = rem_q; sec_d = sec_q; tflags_d = tflags_q; tph_d = tph_q;
    first_d = first_q; cnt_d = cnt_q; ovf_d = ovf_q; rate_d = rate_q;
    wr_en = 1'b0; wr_data = {tflags_q[1:0], first_q, b};
    fin = 1'b0; nb = bidx_q + 8'd1;
    if (cmd_i.take_byte) begin
      if (in_i.resync) h = 2'd0;
      unique case (h)
        2'd0: hunt_d = (b == cpd_pkg::SYNC0) ? 2'd1 : 2'd0;
        2'd1: begin
          if (b == cpd_pkg::SYNC1) hunt_d = 2'd2;
          else if (b != cpd_pkg::SYNC0) hunt_d = 2'd0;
          else hunt_d = 2'd1;
        end
        2'd2: begin
          len_d = b; sum_d = cpd_pkg::SYNC0 + cpd_pkg::SYNC1 + b; bidx_d = 8'd3;
          sec_d = cpd_pkg::SEC_ID; rem_d = '0; tph_d = '0; tflags_d = '0;
          first_d = '0; cnt_d = '0; ovf_d = 1'b0; rate_d = '0;
          if (b <= 8'd3) begin fin = 1'b1; hunt_d = 2'd0; end
          else hunt_d = 2'd3;
        end
        default: begin
          sum_d = sum_q + b;
          if (bidx_q == 8'd3) rate_d = b[7:4];
          else if (bidx_q >= 8'd7) begin
            unique case (sec_q)
              cpd_pkg::SEC_ID: begin
                if (b == cpd_pkg::ID_TC) begin rem_d = 8'd4; sec_d = cpd_pkg::SEC_SKIP; end
                else if (b == cpd_pkg::ID_CC) sec_d = cpd_pkg::SEC_CCCOUNT;
                else if (b == cpd_pkg::ID_SVC) sec_d = cpd_pkg::SEC_SVCCNT;
                else if (b == cpd_pkg::ID_FOOT) begin
                  rem_d = 8'd3; sec_d = cpd_pkg::SEC_SKIP;
                end
                else if (b == cpd_pkg::ID_PAD) sec_d = cpd_pkg::SEC_ID;
                else if (b >= cpd_pkg::ID_FUT0 && b <= cpd_pkg::ID_FUT1)
                  sec_d = cpd_pkg::SEC_FUTLEN;
                else sec_d = cpd_pkg::SEC_DEAD;
              end
              cpd_pkg::SEC_SKIP: begin
                rem_d = rem_q - 8'd1;
                if (rem_d == 8'd0) sec_d = cpd_pkg::SEC_ID;
              end
              cpd_pkg::SEC_CCCOUNT: begin
                rem_d = {3'd0, b[4:0]}; tph_d = '0;
                sec_d = (b[4:0] != 5'd0) ? cpd_pkg::SEC_TRIPLET : cpd_pkg::SEC_ID;
              end
              cpd_pkg::SEC_TRIPLET: begin
                if (tph_q == 2'd0) begin tflags_d = b[2:0]; tph_d = 2'd1; end
                else if (tph_q == 2'd1) begin first_d = b; tph_d = 2'd2; end
                else begin
                  if (tflags_q[2]) begin
                    if (cnt_q < CntMax) begin wr_en = 1'b1; cnt_d = cnt_q + 1'b1; end
                    else ovf_d = 1'b1;
                  end
                  tph_d = 2'd0; rem_d = rem_q - 8'd1;
                  if (rem_d == 8'd0) sec_d = cpd_pkg::SEC_ID;
                end
              end
              cpd_pkg::SEC_SVCCNT: begin
                rem_d = 8'({4'd0, b[3:0]} * 8'd7);
                sec_d = (b[3:0] != 4'd0) ? cpd_pkg::SEC_SKIP : cpd_pkg::SEC_ID;
              end
              cpd_pkg::SEC_FUTLEN: begin
                rem_d = b;
                sec_d = (b != 8'd0) ? cpd_pkg::SEC_SKIP : cpd_pkg::SEC_ID;
              end
              default: sec_d = cpd_pkg::SEC_DEAD;
            endcase
          end
          bidx_d = nb;
          if (nb >= len_q) begin fin = 1'b1; hunt_d = 2'd0; end
        end
      endcase
    end
    fin_d = fin;
    good_d = fin && (sum_d == 8'd0) && (len_d >= 8'd7);
    min_d = min_q; max_d = max_q;
    if (good_d) begin
      if (len_d < min_q) min_d = len_d;
      if (len_d > max_q) max_d = len_d;
    end
  end

  // read index of the next cycle; the store read runs one entry ahead
  always_comb begin
    if (cmd_i.rd_start) rd_addr = '0;
    else if (cmd_i.rd_next) rd_addr = rd_q + 1'b1;
    else rd_addr = rd_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hunt_q <= '0; bidx_q <= '0; len_q <= '0; sum_q <= '0; rem_q <= '0;
      sec_q <= cpd_pkg::SEC_ID; tph_q <= '0; tflags_q <= '0; first_q <= '0;
      cnt_q <= '0; ovf_q <= 1'b0; rate_q <= '0; min_q <= 8'hFF; max_q <= '0;
      fin_q <= 1'b0; good_q <= 1'b0; rd_q <= '0;
    end else begin
      hunt_q <= hunt_d; bidx_q <= bidx_d; len_q <= len_d; sum_q <= sum_d;
      rem_q <= rem_d; sec_q <= sec_d; tph_q <= tph_d; tflags_q <= tflags_d;
      first_q <= first_d; cnt_q <= cnt_d; ovf_q <= ovf_d; rate_q <= rate_d;
      min_q <= min_d; max_q <= max_d;
      fin_q <= fin_d;
      if (cmd_i.take_byte) good_q <= good_d;
      rd_q <= rd_addr;
    end
  end

  // pair store; rd_data holds the entry at rd_q
  always_ff @(posedge clk_i) begin
    if (wr_en) store[cnt_q[IdxW-1:0]] <= wr_data;
    rd_data <= store[rd_addr[IdxW-1:0]];
  end

  assign sts_o.finish = fin_q;
  assign sts_o.good = good_q;
  assign sts_o.more_pairs = rd_q < cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pair) begin
      out_o.record_kind <= cpd_pkg::KIND_PAIR;
      out_o.channel     <= (rd_data[17:16] == 2'd3) ? 2'd2 : rd_data[17:16];
      out_o.pair_type   <= rd_data[17:16];
      out_o.pair_first  <= rd_data[15:8];
      out_o.pair_second <= rd_data[7:0];
      out_o.last        <= 1'b0;
    end else if (cmd_i.load_end) begin
      out_o.record_kind <= cpd_pkg::KIND_END;
      out_o.channel     <= '0;
      out_o.pair_type   <= '0;
      out_o.pair_first  <= '0;
      out_o.pair_second <= '0;
      out_o.last        <= 1'b1;
    end
    if (cmd_i.load_pair || cmd_i.load_end) begin
      out_o.rate_code     <= rate_q;
      out_o.packet_size   <= len_q;
      out_o.sum_good      <= good_q;
      out_o.pairs_lost    <= ovf_q;
      out_o.shortest_seen <= min_q;
      out_o.longest_seen  <= max_q;
    end
  end
endmodule

// File: sv/cpd_controller.sv
// Controller: input handshake, release burst sequencing and output valid.
// Depends on cpd_pkg.
`timescale 1ns / 1ps
module cpd_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  cpd_pkg::sts_t sts_i,
  output cpd_pkg::cmd_t cmd_o
);
  localparam logic [1:0] ST_RUN  = 2'd0;  // taking bytes
  localparam logic [1:0] ST_CHK  = 2'd1;  // byte just taken; check for packet end
  localparam logic [1:0] ST_PAIR = 2'd2;  // store read in flight / pair to load
  localparam logic [1:0] ST_END  = 2'd3;  // end record pending

  logic [1:0] st_q, st_d;
  logic       ov_q, ov_d;
  logic       slot;

  // output register is free this cycle
  assign slot = !ov_q || out_ready_i;

  always_comb begin
    st_d = st_q; ov_d = ov_q && !out_ready_i;
    cmd_o = '0;
    in_ready_o = (st_q == ST_RUN);
    cmd_o.take_byte = in_valid_i && in_ready_o;
    unique case (st_q)
      ST_RUN: if (cmd_o.take_byte) st_d = ST_CHK;
      ST_CHK: begin
        cmd_o.rd_start = 1'b1;
        if (!sts_i.finish) st_d = ST_RUN;
        else if (sts_i.good) st_d = ST_PAIR;
        else st_d = ST_END;
      end
      ST_PAIR: begin
        if (!sts_i.more_pairs) st_d = ST_END;
        else if (slot) begin
          cmd_o.load_pair = 1'b1; cmd_o.rd_next = 1'b1; ov_d = 1'b1;
        end
      end
      default: begin
        if (slot) begin cmd_o.load_end = 1'b1; ov_d = 1'b1; st_d = ST_RUN; end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RUN; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; ov_q <= ov_d;
    end
  end

  assign out_valid_o = ov_q;
endmodule

// File: sv/caption_packet_deframer_unit.sv
// Top level of the caption packet deframer: controller plus datapath.
// Depends on cpd_pkg, cpd_controller, cpd_datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one stream byte and
//   a resync flag per transfer. Output channel (out_valid_o/out_ready_i/out_data_o)
//   carries caption pair records and one end record per finished packet.
// Sequencing:
//   Each byte is parsed into the section state when taken; the controller then
//   checks whether the packet ended, and takes no new byte before that check.
//   At a good packet end, the buffered pairs pass one by one from the pair-store
//   read port into the output register, a last ST_PAIR step sees the store drained,
//   then the end record is loaded; input is held until then. A bad packet emits
//   only its end record and holds input until that record is loaded.
// Stall:
//   The single output register holds a record until it is taken; the release
//   sequencer waits, and input stays blocked until the end record is loaded.
// Reset:
//   Asynchronous, active low. Hunt restarts, statistics return to 255 / 0.
//   The pair store has no reset; only entries written in the current packet are read.
module caption_packet_deframer_unit #(
  parameter int unsigned MaxPairs = cpd_pkg::MaxPairsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  cpd_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output cpd_pkg::out_item_t  out_data_o
);
  cpd_pkg::cmd_t cmd;
  cpd_pkg::sts_t sts;

  cpd_controller u_ctl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  cpd_datapath #(.MaxPairs(MaxPairs)) u_dp (
    .clk_i, .rst_ni, .in_i(in_data_i), .cmd_i(cmd), .sts_o(sts), .out_o(out_data_o)
  );
endmodule
